FILE: rtl/ham8_pkg.sv
// ----------------------------------------------------------------------------
// ham8_pkg
// types, control codes and scoring helpers shared by the hold-and-modify encoder
// ----------------------------------------------------------------------------
package ham8_pkg;

    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 6;
    localparam int SCORE_W = 14;
    localparam int CODE_W  = 8;

    typedef enum logic [1:0] {
        CTL_PALETTE = 2'd0,
        CTL_BLUE    = 2'd1,
        CTL_RED     = 2'd2,
        CTL_GREEN   = 2'd3
    } ctl_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        rgb_t               color;
        logic               line_start;
        logic               grey_valid;
        logic [INDEX_W-1:0] grey_index;
    } pixel_t;

    typedef struct packed {
        rgb_t              held;
        logic [CODE_W-1:0] pixel_code;
    } encode_t;

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [SCORE_W-1:0] score(input rgb_t h, input rgb_t p);
        logic [SCORE_W-1:0] dr;
        logic [SCORE_W-1:0] dg;
        logic [SCORE_W-1:0] db;
        dr = SCORE_W'(absdiff(h.red, p.red));
        dg = SCORE_W'(absdiff(h.green, p.green));
        db = SCORE_W'(absdiff(h.blue, p.blue));
        score = dr * SCORE_W'(9) + dg * SCORE_W'(36) + db;
    endfunction

endpackage

FILE: rtl/ham8_pixel_encoder_unit.sv
// an accepted pixel waits in the input register; its code is registered in the output register once that is free
// throughput: one pixel per cycle while m_tready is high, set by the held-colour loop in ham8_core
// an input register and an output register, s_tready follows m_tready in the same cycle
// reset: rst_n asynchronous active low, clears held colour and all valid flags
// ----------------------------------------------------------------------------
// ham8_pixel_encoder_unit
// hold-and-modify pixel encoder with stream input and output
// ----------------------------------------------------------------------------
module ham8_pixel_encoder_unit
    import ham8_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red, green, blue, grey_index, zero pad
    input  logic [1:0]  s_tuser,   // line_start, grey_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // pixel_code
);

    logic              in_vld_reg;
    pixel_t            pix_reg;
    rgb_t              held_reg;
    logic              out_vld_reg;
    logic [CODE_W-1:0] code_reg;
    logic              fire;
    logic              take;
    encode_t           enc;

    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = code_reg;

    ham8_core u_core
    (
        .held   (held_reg),
        .pix    (pix_reg),
        .result (enc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            held_reg    <= '0;
        end
        else
        begin
            if (take)
                in_vld_reg <= 1'b1;
            else if (fire)
                in_vld_reg <= 1'b0;
            if (fire)
            begin
                out_vld_reg <= 1'b1;
                held_reg    <= enc.held;
            end
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg.color.red   <= s_tdata[7:0];
            pix_reg.color.green <= s_tdata[15:8];
            pix_reg.color.blue  <= s_tdata[23:16];
            pix_reg.grey_index  <= s_tdata[29:24];
            pix_reg.line_start  <= s_tuser[0];
            pix_reg.grey_valid  <= s_tuser[1];
        end
        if (fire)
            code_reg <= enc.pixel_code;
    end

`ifndef SYNTH
    a_fire_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("encoded pixel not presented");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> s_tready)
        else $error("empty input stage refuses a request");

    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(held_reg))
        else $error("held colour changed without an encode");

    a_palette_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && enc.pixel_code[CODE_W-1 -: 2] == CTL_PALETTE) |=>
            (held_reg.red == held_reg.green && held_reg.green == held_reg.blue))
        else $error("palette code left held colour non-grey");
`endif

endmodule

FILE: rtl/ham8_core.sv
// ----------------------------------------------------------------------------
// ham8_core
// one-pixel encode: channel pick by weighted difference, then grey check
// ----------------------------------------------------------------------------
module ham8_core
    import ham8_pkg::*;
(
    input  rgb_t    held,
    input  pixel_t  pix,
    output encode_t result
);

    rgb_t                 base;
    rgb_t                 mod;
    rgb_t                 grey;
    logic [9:0]           wr;
    logic [10:0]          wg;
    logic [10:0]          wb;
    logic [INDEX_W-1:0]   mod_val;
    ctl_t                 mod_ctl;
    logic [CHAN_W-1:0]    level;
    logic [SCORE_W-1:0]   s_mod;
    logic [SCORE_W-1:0]   s_grey;

    always_comb
    begin
        base = pix.line_start ? '0 : held;
        wr = 10'(absdiff(base.red, pix.color.red)) * 10'd3;
        wg = 11'(absdiff(base.green, pix.color.green)) * 11'd6;
        wb = 11'(absdiff(base.blue, pix.color.blue));

        mod = base;
        if (wg >= 11'(wr) && wg >= wb)
        begin
            mod.green = pix.color.green;
            mod_ctl   = CTL_GREEN;
            mod_val   = pix.color.green[CHAN_W-1:2];
        end
        else if (11'(wr) >= wb)
        begin
            mod.red = pix.color.red;
            mod_ctl = CTL_RED;
            mod_val = pix.color.red[CHAN_W-1:2];
        end
        else
        begin
            mod.blue = pix.color.blue;
            mod_ctl  = CTL_BLUE;
            mod_val  = pix.color.blue[CHAN_W-1:2];
        end

        level  = {pix.grey_index, 2'b00};
        grey   = '{red: level, green: level, blue: level};
        s_mod  = score(mod, pix.color);
        s_grey = score(grey, pix.color);

        if (pix.grey_valid && s_mod >= s_grey)
        begin
            result.held       = grey;
            result.pixel_code = {CTL_PALETTE, pix.grey_index};
        end
        else
        begin
            result.held       = mod;
            result.pixel_code = {mod_ctl, mod_val};
        end
    end

endmodule
